### rtl/dlfp_pkg.sv
// Package for the dual link failover policy block.
// Holds widths, codes, defaults and the shared structs; used by every rtl file.
`default_nettype none

package dlfp_pkg;

    // Time and counter widths
    localparam int TIME_BITS         = 48;
    localparam int MAX_BACKOFF_LEVEL = 16;
    localparam int LEVEL_W           = $clog2(MAX_BACKOFF_LEVEL + 1);
    localparam int COUNT_W           = 8;
    localparam int BASE_W            = 16;
    localparam int SPAN_W            = 32;
    localparam int OVR_W             = 2;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 32;
    localparam int SHIFT_W           = BASE_W + MAX_BACKOFF_LEVEL;
    localparam int WAIT_W            = (SHIFT_W > SPAN_W) ? SHIFT_W : SPAN_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(MAX_BACKOFF_LEVEL);

    // Health override modes
    localparam logic [OVR_W-1:0] OVR_AUTO = 2'd0;
    localparam logic [OVR_W-1:0] OVR_DOWN = 2'd1;
    localparam logic [OVR_W-1:0] OVR_UP   = 2'd2;

    // Uplink codes (egress, net status and transport share them)
    localparam logic [1:0] EG_NONE     = 2'd0;
    localparam logic [1:0] EG_WIRED    = 2'd1;
    localparam logic [1:0] EG_WIRELESS = 2'd2;

    // Item kinds
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_JOIN = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIRED_OVR     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIRELESS_OVR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_BASE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_CAP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PING_LIMIT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RETURN_HOLD   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STABLE_WINDOW = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_JOIN_TRIES    = 3'd7;

    // Register defaults after reset
    localparam logic [BASE_W-1:0]  DEF_BACKOFF_BASE  = 16'd1000;
    localparam logic [SPAN_W-1:0]  DEF_BACKOFF_CAP   = 32'd60000;
    localparam logic [COUNT_W-1:0] DEF_PING_LIMIT    = 8'd3;
    localparam logic [SPAN_W-1:0]  DEF_RETURN_HOLD   = 32'd10000;
    localparam logic [SPAN_W-1:0]  DEF_STABLE_WINDOW = 32'd60000;
    localparam logic [COUNT_W-1:0] DEF_JOIN_TRIES    = 8'd3;

    typedef struct packed {
        logic [OVR_W-1:0]   wired_ovr;
        logic [OVR_W-1:0]   wireless_ovr;
        logic [BASE_W-1:0]  backoff_base;
        logic [SPAN_W-1:0]  backoff_cap;
        logic [COUNT_W-1:0] ping_fail_limit;
        logic [SPAN_W-1:0]  return_hold;
        logic [SPAN_W-1:0]  stable_window;
        logic [COUNT_W-1:0] join_reset_tries;
    } cfg_t;

    typedef struct packed {
        logic                 func;
        logic [TIME_BITS-1:0] now;
        logic                 wired_link;
        logic                 wired_has_addr;
        logic                 ping_good;
        logic                 ping_taken;
        logic                 wireless_assoc;
        logic                 wireless_has_addr;
        logic                 join_good;
    } item_t;

    typedef struct packed {
        logic                 last_link;
        logic [COUNT_W-1:0]   ping_fail_count;
        logic                 healthy_valid;
        logic [TIME_BITS-1:0] healthy_since;
        logic                 online_valid;
        logic [TIME_BITS-1:0] online_since;
        logic [LEVEL_W-1:0]   wired_level;
        logic [TIME_BITS-1:0] probe_time;
        logic [1:0]           egress;
        logic [COUNT_W-1:0]   join_fail_count;
        logic [LEVEL_W-1:0]   join_level;
        logic                 reset_request;
    } state_t;

    typedef struct packed {
        logic [1:0]           egress;
        logic [1:0]           net_status;
        logic [1:0]           transport;
        logic                 reconnect;
        logic [TIME_BITS-1:0] next_probe;
        logic                 wired_ok;
        logic                 wireless_ok;
        logic                 module_reset_req;
        logic [LEVEL_W-1:0]   join_backoff_level;
    } result_t;

endpackage

`default_nettype wire

### rtl/dlfp_step.sv
// Per-transaction policy logic: next state and result from the current state.
// Pure combinational; depends on dlfp_pkg.
`default_nettype none

module dlfp_step
    import dlfp_pkg::*;
(
    input  wire cfg_t    cfg,
    input  wire state_t  cur,
    input  wire item_t   item,
    output state_t  nxt,
    output result_t res
);

    logic                 rise;
    logic                 wok;
    logic                 fok;
    logic [COUNT_W-1:0]   ping_cnt;
    logic [WAIT_W-1:0]    wait_shift;
    logic [SPAN_W-1:0]    wait_ms;
    logic [TIME_BITS:0]   probe_sum;
    logic [TIME_BITS-1:0] online_age;
    logic [TIME_BITS-1:0] healthy_ref;
    logic [TIME_BITS-1:0] healthy_age;
    logic [1:0]           desired;
    logic [COUNT_W-1:0]   jcnt;

    // Backoff wait for the current level: base doubled per level, capped
    assign wait_shift = WAIT_W'(cfg.backoff_base) << cur.wired_level;
    assign wait_ms    = (wait_shift > WAIT_W'(cfg.backoff_cap)) ?
                        cfg.backoff_cap : wait_shift[SPAN_W-1:0];
    assign probe_sum  = {1'b0, item.now} + (TIME_BITS + 1)'(wait_ms);

    assign online_age  = item.now - cur.online_since;
    assign healthy_ref = cur.healthy_valid ? cur.healthy_since : item.now;
    assign healthy_age = item.now - healthy_ref;
    assign rise        = item.wired_link & ~cur.last_link;

    // Wireless health with override
    always_comb
    begin
        case (cfg.wireless_ovr)
            OVR_DOWN: fok = 1'b0;
            OVR_UP:   fok = 1'b1;
            default:  fok = item.wireless_assoc & item.wireless_has_addr;
        endcase
    end

    // Wired health with override and ping failure count
    always_comb
    begin
        ping_cnt = cur.ping_fail_count;
        case (cfg.wired_ovr)
            OVR_AUTO:
            begin
                if (item.ping_taken)
                begin
                    if (!item.ping_good)
                    begin
                        if (ping_cnt != COUNT_MAX)
                            ping_cnt = ping_cnt + 1'b1;
                    end
                    else
                        ping_cnt = '0;
                end
                wok = item.wired_link & item.wired_has_addr &
                      (ping_cnt < cfg.ping_fail_limit);
            end
            OVR_UP:
            begin
                ping_cnt = '0;
                wok      = 1'b1;
            end
            default:
            begin
                ping_cnt = cfg.ping_fail_limit;
                wok      = 1'b0;
            end
        endcase
    end

    // Uplink choice: wired preferred, return from wireless after the hold
    always_comb
    begin
        if (wok)
        begin
            if (cur.egress == EG_WIRELESS)
                desired = (healthy_age >= TIME_BITS'(cfg.return_hold)) ?
                          EG_WIRED : EG_WIRELESS;
            else
                desired = EG_WIRED;
        end
        else if (fok)
            desired = EG_WIRELESS;
        else
            desired = EG_NONE;
    end

    // Next state and result
    always_comb
    begin
        nxt  = cur;
        jcnt = cur.join_fail_count;
        if (item.func == FUNC_JOIN)
        begin
            // join result: count failures, raise the module reset request
            nxt.reset_request = 1'b0;
            if (item.join_good)
            begin
                nxt.join_fail_count = '0;
                nxt.join_level      = '0;
            end
            else
            begin
                if (jcnt != COUNT_MAX)
                    jcnt = jcnt + 1'b1;
                if (jcnt >= cfg.join_reset_tries)
                begin
                    nxt.reset_request = 1'b1;
                    jcnt              = '0;
                end
                nxt.join_fail_count = jcnt;
                if (cur.join_level < LEVEL_MAX)
                    nxt.join_level = cur.join_level + 1'b1;
            end
        end
        else
        begin
            nxt.last_link       = item.wired_link;
            nxt.ping_fail_count = ping_cnt;
            if (rise)
                nxt.probe_time = item.now;
            if (wok)
            begin
                nxt.probe_time = item.now;
                if (!cur.healthy_valid)
                begin
                    nxt.healthy_valid = 1'b1;
                    nxt.healthy_since = item.now;
                end
                if (!cur.online_valid)
                begin
                    nxt.online_valid = 1'b1;
                    nxt.online_since = item.now;
                end
                else if (online_age >= TIME_BITS'(cfg.stable_window))
                    nxt.wired_level = '0;
            end
            else
            begin
                nxt.healthy_valid = 1'b0;
                nxt.healthy_since = '0;
                // failed probe: push the next probe out, saturating
                if (cfg.wired_ovr == OVR_AUTO && item.ping_taken && !item.ping_good && !rise)
                begin
                    if (cur.wired_level < LEVEL_MAX)
                        nxt.wired_level = cur.wired_level + 1'b1;
                    nxt.probe_time = probe_sum[TIME_BITS] ? {TIME_BITS{1'b1}} :
                                     probe_sum[TIME_BITS-1:0];
                end
            end
            nxt.egress = desired;
        end

        res.egress             = nxt.egress;
        res.net_status         = nxt.egress;
        res.transport          = nxt.egress;
        res.reconnect          = (item.func == FUNC_TICK) && (desired != cur.egress);
        res.next_probe         = nxt.probe_time;
        res.wired_ok           = (item.func == FUNC_TICK) && wok;
        res.wireless_ok        = (item.func == FUNC_TICK) && fok;
        res.module_reset_req   = nxt.reset_request;
        res.join_backoff_level = nxt.join_level;
    end

endmodule

`default_nettype wire

### rtl/dual_link_failover_policy.sv
// Top level of the dual link failover policy: ports, registers, pipeline control.
// Depends on dlfp_pkg and dlfp_step.
`default_nettype none

// Picks the active uplink (wired or wireless) for each tick transaction and
// tracks wireless join failures for join transactions; one result per input.
// Each transaction waits in the input register until it can advance and then lands
// in the output register, so the block takes one transaction every clock cycle
// while out_stall is low, and out_valid rises once the transaction reaches the
// output register and its result is offered. The policy state is
// updated in the cycle the transaction moves into the output register, so the
// next transaction sees it at once. An input is still taken while a result
// waits on out_stall, as long as the input register is free. Configuration
// writes take effect on the next cycle and belong in idle periods.

module dual_link_failover_policy
    import dlfp_pkg::*;
(
    input  wire                    clk,
    input  wire                    rst_n,
    // configuration
    input  wire                    cfg_write,
    input  wire  [CFG_IDX_W-1:0]   cfg_index,
    input  wire  [CFG_DATA_W-1:0]  cfg_data,
    // input channel
    input  wire                    in_valid,
    output logic                   in_stall,
    input  wire                    func,
    input  wire  [TIME_BITS-1:0]   now,
    input  wire                    wired_link,
    input  wire                    wired_has_addr,
    input  wire                    ping_good,
    input  wire                    ping_taken,
    input  wire                    wireless_assoc,
    input  wire                    wireless_has_addr,
    input  wire                    join_good,
    // output channel
    output logic                   out_valid,
    input  wire                    out_stall,
    output logic [1:0]             egress,
    output logic [1:0]             net_status,
    output logic [1:0]             transport,
    output logic                   reconnect,
    output logic [TIME_BITS-1:0]   next_probe,
    output logic                   wired_ok,
    output logic                   wireless_ok,
    output logic                   module_reset_req,
    output logic [LEVEL_W-1:0]     join_backoff_level
);

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    item_t   item_reg;
    result_t res_reg;
    result_t res_next;
    logic    in_valid_reg;
    logic    out_valid_reg;
    logic    advance;
    logic    in_take;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wired_ovr        <= OVR_AUTO;
            cfg_reg.wireless_ovr     <= OVR_AUTO;
            cfg_reg.backoff_base     <= DEF_BACKOFF_BASE;
            cfg_reg.backoff_cap      <= DEF_BACKOFF_CAP;
            cfg_reg.ping_fail_limit  <= DEF_PING_LIMIT;
            cfg_reg.return_hold      <= DEF_RETURN_HOLD;
            cfg_reg.stable_window    <= DEF_STABLE_WINDOW;
            cfg_reg.join_reset_tries <= DEF_JOIN_TRIES;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_WIRED_OVR:     cfg_reg.wired_ovr        <= cfg_data[OVR_W-1:0];
                REG_WIRELESS_OVR:  cfg_reg.wireless_ovr     <= cfg_data[OVR_W-1:0];
                REG_BACKOFF_BASE:  cfg_reg.backoff_base     <= cfg_data[BASE_W-1:0];
                REG_BACKOFF_CAP:   cfg_reg.backoff_cap      <= cfg_data[SPAN_W-1:0];
                REG_PING_LIMIT:    cfg_reg.ping_fail_limit  <= cfg_data[COUNT_W-1:0];
                REG_RETURN_HOLD:   cfg_reg.return_hold      <= cfg_data[SPAN_W-1:0];
                REG_STABLE_WINDOW: cfg_reg.stable_window    <= cfg_data[SPAN_W-1:0];
                REG_JOIN_TRIES:    cfg_reg.join_reset_tries <= cfg_data[COUNT_W-1:0];
                default:           cfg_reg.join_reset_tries <= cfg_reg.join_reset_tries;
            endcase
        end
    end

    // Input stage: hold the accepted transaction until it advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.func              <= func;
            item_reg.now               <= now;
            item_reg.wired_link        <= wired_link;
            item_reg.wired_has_addr    <= wired_has_addr;
            item_reg.ping_good         <= ping_good;
            item_reg.ping_taken        <= ping_taken;
            item_reg.wireless_assoc    <= wireless_assoc;
            item_reg.wireless_has_addr <= wireless_has_addr;
            item_reg.join_good         <= join_good;
        end
    end

    dlfp_step u_step (
        .cfg  (cfg_reg),
        .cur  (state_reg),
        .item (item_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    // Policy state: update as the transaction advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (advance)
            state_reg <= state_next;
    end

    // Output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign out_valid          = out_valid_reg;
    assign egress             = res_reg.egress;
    assign net_status         = res_reg.net_status;
    assign transport          = res_reg.transport;
    assign reconnect          = res_reg.reconnect;
    assign next_probe         = res_reg.next_probe;
    assign wired_ok           = res_reg.wired_ok;
    assign wireless_ok        = res_reg.wireless_ok;
    assign module_reset_req   = res_reg.module_reset_req;
    assign join_backoff_level = res_reg.join_backoff_level;

endmodule

`default_nettype wire

### rtl/dlfp_checker.sv
// Port-level checks for dual_link_failover_policy, bound to the top level.
// Depends on dlfp_pkg.
`default_nettype none

module dlfp_checker
    import dlfp_pkg::*;
(
    input wire                 clk,
    input wire                 rst_n,
    input wire                 out_valid,
    input wire                 out_stall,
    input wire [1:0]           egress,
    input wire [1:0]           net_status,
    input wire [1:0]           transport,
    input wire                 wired_ok,
    input wire                 wireless_ok,
    input wire [LEVEL_W-1:0]   join_backoff_level
);

    // A stalled result transaction stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out_valid dropped while stalled");

    // Status and transport follow the chosen uplink
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (net_status == egress) && (transport == egress))
        else $error("net_status or transport disagrees with egress");

    // A healthy wired link always leaves some uplink active
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && wired_ok |-> (egress == EG_WIRED) || (egress == EG_WIRELESS))
        else $error("wired healthy but no uplink");

    // Only wireless healthy means wireless is the uplink
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && wireless_ok && !wired_ok |-> egress == EG_WIRELESS)
        else $error("wireless only healthy but egress not wireless");

    // Join backoff level saturates
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> join_backoff_level <= LEVEL_MAX)
        else $error("join backoff level above its maximum");

endmodule

bind dual_link_failover_policy dlfp_checker u_dlfp_checker (.*);

`default_nettype wire

### bench/tb_dual_link_failover_policy.sv
// Self-checking bench for dual_link_failover_policy: a directed table, then random phases.
// Depends on dlfp_pkg and the rtl top level; every transaction is predicted in the bench.
`timescale 1ns / 1ps

module tb_dual_link_failover_policy;
    import dlfp_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
    localparam logic [OVR_W-1:0] OVR_SPARE = 2'd3;

    typedef struct {
        item_t   stim;
        bit      typed;
        result_t want;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    item_t                 in_item = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [1:0]            egress;
    logic [1:0]            net_status;
    logic [1:0]            transport;
    logic                  reconnect;
    logic [TIME_BITS-1:0]  next_probe;
    logic                  wired_ok;
    logic                  wireless_ok;
    logic                  module_reset_req;
    logic [LEVEL_W-1:0]    join_backoff_level;

    // Register copies, at their reset values
    logic [OVR_W-1:0]   set_wired_ovr    = OVR_AUTO;
    logic [OVR_W-1:0]   set_wireless_ovr = OVR_AUTO;
    logic [BASE_W-1:0]  set_base         = DEF_BACKOFF_BASE;
    logic [SPAN_W-1:0]  set_cap          = DEF_BACKOFF_CAP;
    logic [COUNT_W-1:0] set_ping_limit   = DEF_PING_LIMIT;
    logic [SPAN_W-1:0]  set_hold         = DEF_RETURN_HOLD;
    logic [SPAN_W-1:0]  set_stable       = DEF_STABLE_WINDOW;
    logic [COUNT_W-1:0] set_join_tries   = DEF_JOIN_TRIES;

    // Policy state as the bench sees it
    logic                 p_last_link     = 1'b0;
    logic [COUNT_W-1:0]   p_ping_fails    = '0;
    logic                 p_healthy_valid = 1'b0;
    logic [TIME_BITS-1:0] p_healthy_since = '0;
    logic                 p_online_valid  = 1'b0;
    logic [TIME_BITS-1:0] p_online_since  = '0;
    logic [LEVEL_W-1:0]   p_wired_level   = '0;
    logic [TIME_BITS-1:0] p_probe         = '0;
    logic [1:0]           p_egress        = EG_NONE;
    logic [COUNT_W-1:0]   p_join_fails    = '0;
    logic [LEVEL_W-1:0]   p_join_level    = '0;
    logic                 p_reset_req     = 1'b0;

    result_t expected_uplink[$];
    int      mismatches = 0;
    int      quiet_cycles = 0;
    int      stall_left = 0;
    bit      calm = 1'b0;

    dual_link_failover_policy u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_write          (cfg_write),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .func               (in_item.func),
        .now                (in_item.now),
        .wired_link         (in_item.wired_link),
        .wired_has_addr     (in_item.wired_has_addr),
        .ping_good          (in_item.ping_good),
        .ping_taken         (in_item.ping_taken),
        .wireless_assoc     (in_item.wireless_assoc),
        .wireless_has_addr  (in_item.wireless_has_addr),
        .join_good          (in_item.join_good),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .egress             (egress),
        .net_status         (net_status),
        .transport          (transport),
        .reconnect          (reconnect),
        .next_probe         (next_probe),
        .wired_ok           (wired_ok),
        .wireless_ok        (wireless_ok),
        .module_reset_req   (module_reset_req),
        .join_backoff_level (join_backoff_level)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic result_t uplink_result(logic [1:0] eg, logic rc,
                                              logic [TIME_BITS-1:0] probe, logic wok,
                                              logic fok, logic req,
                                              logic [LEVEL_W-1:0] lvl);
        result_t r;
        r.egress             = eg;
        r.net_status         = eg;
        r.transport          = eg;
        r.reconnect          = rc;
        r.next_probe         = probe;
        r.wired_ok           = wok;
        r.wireless_ok        = fok;
        r.module_reset_req   = req;
        r.join_backoff_level = lvl;
        return r;
    endfunction

    function automatic item_t mk_tick(logic [TIME_BITS-1:0] t, logic link, logic addr,
                                      logic good, logic taken, logic assoc,
                                      logic radio_addr);
        item_t it;
        it = '0;
        it.func              = FUNC_TICK;
        it.now               = t;
        it.wired_link        = link;
        it.wired_has_addr    = addr;
        it.ping_good         = good;
        it.ping_taken        = taken;
        it.wireless_assoc    = assoc;
        it.wireless_has_addr = radio_addr;
        return it;
    endfunction

    function automatic item_t mk_join(logic good);
        item_t it;
        it = '0;
        it.func      = FUNC_JOIN;
        it.join_good = good;
        return it;
    endfunction

    // Advance the policy state by one transaction and return the uplink decision
    function automatic result_t predict_uplink(item_t it);
        logic                 rise;
        logic                 wok;
        logic                 fok;
        logic                 capped;
        logic [1:0]           prev;
        logic [1:0]           pick;
        logic [63:0]          wait_ms;
        logic [63:0]          headroom;
        logic [TIME_BITS-1:0] elapsed;
        int                   i;

        // Join results touch only the join counters and the reset request
        if (it.func == FUNC_JOIN) begin
            p_reset_req = 1'b0;
            if (it.join_good) begin
                p_join_fails = '0;
                p_join_level = '0;
            end else begin
                if (p_join_fails != COUNT_MAX)
                    p_join_fails = p_join_fails + 1'b1;
                if (p_join_fails >= set_join_tries) begin
                    p_reset_req  = 1'b1;
                    p_join_fails = '0;
                end
                if (p_join_level < LEVEL_MAX)
                    p_join_level = p_join_level + 1'b1;
            end
            return uplink_result(p_egress, 1'b0, p_probe, 1'b0, 1'b0, p_reset_req,
                                 p_join_level);
        end

        prev = p_egress;
        rise = it.wired_link && !p_last_link;
        p_last_link = it.wired_link;
        if (rise)
            p_probe = it.now;

        // Wireless health: a spare override code behaves as auto
        if (set_wireless_ovr == OVR_DOWN)
            fok = 1'b0;
        else if (set_wireless_ovr == OVR_UP)
            fok = 1'b1;
        else
            fok = it.wireless_assoc && it.wireless_has_addr;

        // Wired health: a spare override code behaves as forced down
        if (set_wired_ovr == OVR_AUTO) begin
            if (it.ping_taken) begin
                if (!it.ping_good) begin
                    if (p_ping_fails != COUNT_MAX)
                        p_ping_fails = p_ping_fails + 1'b1;
                end else begin
                    p_ping_fails = '0;
                end
            end
            wok = it.wired_link && it.wired_has_addr && (p_ping_fails < set_ping_limit);
        end else if (set_wired_ovr == OVR_UP) begin
            p_ping_fails = '0;
            wok = 1'b1;
        end else begin
            p_ping_fails = set_ping_limit;
            wok = 1'b0;
        end

        if (wok) begin
            p_probe = it.now;
            if (!p_healthy_valid) begin
                p_healthy_since = it.now;
                p_healthy_valid = 1'b1;
            end
            if (!p_online_valid) begin
                p_online_since = it.now;
                p_online_valid = 1'b1;
            end else begin
                elapsed = it.now - p_online_since;
                if (elapsed >= set_stable)
                    p_wired_level = '0;
            end
        end else begin
            p_healthy_valid = 1'b0;
            p_healthy_since = '0;
            // Push the next probe out by a capped, doubling wait
            if (set_wired_ovr == OVR_AUTO && it.ping_taken && !it.ping_good && !rise) begin
                wait_ms = set_base;
                capped  = 1'b0;
                for (i = 0; i < p_wired_level && !capped; i++) begin
                    if (wait_ms > set_cap / 2) begin
                        wait_ms = set_cap;
                        capped  = 1'b1;
                    end else begin
                        wait_ms = wait_ms * 2;
                    end
                end
                if (wait_ms > set_cap)
                    wait_ms = set_cap;
                if (p_wired_level < LEVEL_MAX)
                    p_wired_level = p_wired_level + 1'b1;
                headroom = TIME_MAX - it.now;
                p_probe = (wait_ms > headroom) ? TIME_MAX : it.now + wait_ms[TIME_BITS-1:0];
            end
        end

        // Prefer wired, but hold wireless until wired has been healthy long enough
        if (wok) begin
            elapsed = it.now - p_healthy_since;
            if (p_egress == EG_WIRELESS && elapsed < set_hold)
                pick = EG_WIRELESS;
            else
                pick = EG_WIRED;
        end else if (fok) begin
            pick = EG_WIRELESS;
        end else begin
            pick = EG_NONE;
        end

        p_egress = pick;
        return uplink_result(pick, pick != prev, p_probe, wok, fok, p_reset_req,
                             p_join_level);
    endfunction

    // Write one register and mirror it; the caller drops the write enable
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_WIRED_OVR:     set_wired_ovr    = val[OVR_W-1:0];
            REG_WIRELESS_OVR:  set_wireless_ovr = val[OVR_W-1:0];
            REG_BACKOFF_BASE:  set_base         = val[BASE_W-1:0];
            REG_BACKOFF_CAP:   set_cap          = val[SPAN_W-1:0];
            REG_PING_LIMIT:    set_ping_limit   = val[COUNT_W-1:0];
            REG_RETURN_HOLD:   set_hold         = val[SPAN_W-1:0];
            REG_STABLE_WINDOW: set_stable       = val[SPAN_W-1:0];
            REG_JOIN_TRIES:    set_join_tries   = val[COUNT_W-1:0];
            default: ;
        endcase
    endtask

    // Hold off the sender until every expected result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_uplink.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Present one transaction, wait for acceptance, then maybe idle a while
    task automatic send_item(item_t it, bit typed, result_t want);
        result_t guess;
        int      r;
        int      gap;
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        guess = predict_uplink(it);
        expected_uplink.push_back(typed ? want : guess);
        r = $urandom_range(0, 99);
        if (!calm && r >= 60) begin
            gap = (r < 94) ? $urandom_range(1, 3) : $urandom_range(6, 30);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic check_field(string label, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %0d actual %0d", $time, label, want, got);
            mismatches++;
        end
    endtask

    // Check each accepted result and stall the output at random
    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        int      r;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
            got = {egress, net_status, transport, reconnect, next_probe, wired_ok,
                   wireless_ok, module_reset_req, join_backoff_level};
            if (expected_uplink.size() == 0) begin
                $display("%0t ns: result with nothing expected, egress %0d", $time, egress);
                mismatches++;
            end else begin
                want = expected_uplink.pop_front();
                check_field("egress", want.egress, got.egress);
                check_field("net_status", want.net_status, got.net_status);
                check_field("transport", want.transport, got.transport);
                check_field("reconnect", want.reconnect, got.reconnect);
                check_field("next_probe", want.next_probe, got.next_probe);
                check_field("wired_ok", want.wired_ok, got.wired_ok);
                check_field("wireless_ok", want.wireless_ok, got.wireless_ok);
                check_field("module_reset_req", want.module_reset_req, got.module_reset_req);
                check_field("join_backoff_level", want.join_backoff_level,
                            got.join_backoff_level);
            end
        end
        if (stall_left != 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (calm || r < 65) begin
                out_stall <= 1'b0;
            end else begin
                out_stall <= 1'b1;
                stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(5, 30);
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t ns: watchdog expired, %0d results outstanding", $time,
                         expected_uplink.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        stim_row_t            stim_rows[$];
        item_t                it;
        logic [63:0]          noise;
        logic [TIME_BITS-1:0] sim_ms;
        logic [OVR_W-1:0]     w_ovr;
        logic [OVR_W-1:0]     f_ovr;
        logic [BASE_W-1:0]    base;
        logic [SPAN_W-1:0]    cap;
        logic [SPAN_W-1:0]    hold;
        logic [SPAN_W-1:0]    stable;
        logic [COUNT_W-1:0]   limit;
        logic [COUNT_W-1:0]   tries;
        bit                   wired_up;
        bit                   radio_up;
        int                   phase;
        int                   k;
        int                   r;
        int                   n_items;
        int                   p_join;
        int                   p_good;
        int                   p_taken;

        // Directed table under reset settings; typed rows are plain to read off
        stim_rows.push_back('{mk_join(1'b0), 1'b1,
            uplink_result(EG_NONE, 1'b0, '0, 1'b0, 1'b0, 1'b0, 5'd1)});
        stim_rows.push_back('{mk_join(1'b0), 1'b1,
            uplink_result(EG_NONE, 1'b0, '0, 1'b0, 1'b0, 1'b0, 5'd2)});
        stim_rows.push_back('{mk_join(1'b0), 1'b1,
            uplink_result(EG_NONE, 1'b0, '0, 1'b0, 1'b0, 1'b1, 5'd3)});
        stim_rows.push_back('{mk_tick('0, 0, 0, 0, 0, 0, 0), 1'b1,
            uplink_result(EG_NONE, 1'b0, '0, 1'b0, 1'b0, 1'b1, 5'd3)});
        stim_rows.push_back('{mk_join(1'b1), 1'b1,
            uplink_result(EG_NONE, 1'b0, '0, 1'b0, 1'b0, 1'b0, 5'd0)});
        stim_rows.push_back('{mk_tick(48'd100, 1, 1, 0, 0, 1, 1), 1'b1,
            uplink_result(EG_WIRED, 1'b1, 48'd100, 1'b1, 1'b1, 1'b0, 5'd0)});
        // ping failures up to the limit, then backoff on wireless
        stim_rows.push_back('{mk_tick(48'd200, 1, 1, 0, 1, 1, 1), 1'b0, '0});
        stim_rows.push_back('{mk_tick(48'd300, 1, 1, 0, 1, 1, 1), 1'b0, '0});
        stim_rows.push_back('{mk_tick(48'd400, 1, 1, 0, 1, 1, 1), 1'b0, '0});
        stim_rows.push_back('{mk_tick(48'd500, 1, 1, 0, 1, 1, 1), 1'b0, '0});
        // wired recovers but must hold before the return from wireless
        stim_rows.push_back('{mk_tick(48'd600, 1, 1, 1, 1, 1, 1), 1'b0, '0});
        stim_rows.push_back('{mk_tick(48'd10600, 1, 1, 0, 0, 1, 1), 1'b0, '0});
        stim_rows.push_back('{mk_tick(48'd80000, 1, 1, 0, 0, 0, 0), 1'b0, '0});
        // time running backward, both links down
        stim_rows.push_back('{mk_tick(48'd50, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        // link rise near the top of time, then failures that saturate the probe time
        stim_rows.push_back('{mk_tick(TIME_MAX - 100, 1, 0, 0, 1, 0, 1), 1'b0, '0});
        stim_rows.push_back('{mk_tick(TIME_MAX - 50, 1, 0, 0, 1, 1, 0), 1'b0, '0});
        stim_rows.push_back('{mk_tick(TIME_MAX, 1, 0, 0, 1, 0, 0), 1'b0, '0});
        stim_rows.push_back('{mk_tick('0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        stim_rows.push_back('{item_t'('1), 1'b0, '0});
        stim_rows.push_back('{mk_tick(TIME_MAX, 1, 1, 1, 1, 1, 1), 1'b0, '0});

        // Hold reset low, then release it
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        calm = 1'b1;
        foreach (stim_rows[i])
            send_item(stim_rows[i].stim, stim_rows[i].typed, stim_rows[i].want);
        calm = 1'b0;

        sim_ms   = 48'd5000;
        wired_up = 1'b1;
        radio_up = 1'b1;

        for (phase = 1; phase <= 9; phase++) begin
            // Pick a setting; the first phases pin the extremes and spare codes
            w_ovr   = ($urandom_range(0, 99) < 80) ? OVR_AUTO : OVR_W'($urandom_range(0, 3));
            f_ovr   = ($urandom_range(0, 99) < 70) ? OVR_AUTO : OVR_W'($urandom_range(0, 3));
            base    = BASE_W'($urandom_range(1, 4000));
            cap     = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 200000);
            limit   = COUNT_W'($urandom_range(1, 6));
            hold    = $urandom_range(0, 30000);
            stable  = $urandom_range(0, 200000);
            tries   = COUNT_W'($urandom_range(1, 6));
            n_items = 165;
            p_join  = 15;
            p_good  = 65;
            p_taken = 55;
            case (phase)
                1: begin
                    w_ovr = OVR_AUTO; f_ovr = OVR_AUTO;
                    base = 16'd1; cap = 32'd1; limit = 8'd1;
                    hold = '0; stable = '0; tries = 8'd1;
                end
                2: begin
                    w_ovr = OVR_AUTO; f_ovr = OVR_AUTO;
                    base = '1; cap = '1; limit = '1;
                    hold = '1; stable = '1; tries = '1;
                    n_items = 330; p_join = 10; p_good = 0; p_taken = 95;
                end
                3: begin
                    w_ovr = OVR_DOWN; f_ovr = OVR_UP;
                end
                4: begin
                    w_ovr = OVR_UP; f_ovr = OVR_DOWN;
                end
                5: begin
                    w_ovr = OVR_SPARE; f_ovr = OVR_SPARE;
                    base = '0; cap = '0; limit = '0; tries = '0;
                end
                default: ;
            endcase

            // Reprogram only while the block is idle
            drain_results();
            write_reg(REG_WIRED_OVR, {(CFG_DATA_W - OVR_W)'($urandom), w_ovr});
            write_reg(REG_WIRELESS_OVR, {(CFG_DATA_W - OVR_W)'($urandom), f_ovr});
            write_reg(REG_BACKOFF_BASE, {(CFG_DATA_W - BASE_W)'($urandom), base});
            write_reg(REG_BACKOFF_CAP, cap);
            write_reg(REG_PING_LIMIT, {(CFG_DATA_W - COUNT_W)'($urandom), limit});
            write_reg(REG_RETURN_HOLD, hold);
            write_reg(REG_STABLE_WINDOW, stable);
            write_reg(REG_JOIN_TRIES, {(CFG_DATA_W - COUNT_W)'($urandom), tries});
            cfg_write <= 1'b0;
            repeat (2) @(posedge clk);

            for (k = 0; k < n_items; k++) begin
                if (k % 40 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                if (k == n_items / 2)
                    drain_results();

                // Start from random bits so ignored fields see both values too
                noise = {$urandom, $urandom};
                it = noise[$bits(item_t)-1:0];
                if ($urandom_range(0, 99) < p_join) begin
                    it.func = FUNC_JOIN;
                end else begin
                    it.func = FUNC_TICK;
                    // Advance time: short steps, long jumps, anywhere, or near the top
                    r = $urandom_range(0, 99);
                    if (r < 70)
                        sim_ms = sim_ms + TIME_BITS'($urandom_range(0, 2500));
                    else if (r < 90)
                        sim_ms = sim_ms + TIME_BITS'($urandom_range(2500, 40000));
                    else if (r < 95)
                        sim_ms = sim_ms + TIME_BITS'($urandom);
                    else if (r < 98)
                        sim_ms = noise[63:64-TIME_BITS];
                    else
                        sim_ms = TIME_MAX - TIME_BITS'($urandom_range(0, 50000));
                    it.now = sim_ms;
                    // Most ticks follow slowly changing links; the rest keep raw noise
                    if ($urandom_range(0, 99) >= 12) begin
                        if ($urandom_range(0, 99) < 8)
                            wired_up = !wired_up;
                        if ($urandom_range(0, 99) < 5)
                            radio_up = !radio_up;
                        it.wired_link        = wired_up;
                        it.wired_has_addr    = wired_up ? ($urandom_range(0, 99) < 92)
                                                        : ($urandom_range(0, 99) < 10);
                        it.ping_taken        = ($urandom_range(0, 99) < p_taken);
                        it.ping_good         = ($urandom_range(0, 99) < p_good);
                        it.wireless_assoc    = radio_up;
                        it.wireless_has_addr = radio_up ? ($urandom_range(0, 99) < 90)
                                                        : ($urandom_range(0, 99) < 10);
                    end
                end
                send_item(it, 1'b0, '0);
            end
        end

        drain_results();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
